>>> rtl/core/flc_pkg.sv
package flc_pkg;

   // kernel length and operand width
   localparam int MAX_TAPS    = 32;
   localparam int SAMPLE_BITS = 16;

   // derived widths
   localparam int IDX_BITS  = $clog2(MAX_TAPS);
   localparam int TAP_BITS  = $clog2(MAX_TAPS) + 1;
   localparam int PROD_BITS = 2 * SAMPLE_BITS;
   localparam int ACC_BITS  = PROD_BITS + $clog2(MAX_TAPS);

   // adder tree shape
   localparam int LEVELS = $clog2(MAX_TAPS);
   localparam int LEAVES = 1 << LEVELS;
   localparam int NODES  = LEAVES - 1;

   // function codes of an input word
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // control travelling alongside the data through the pipeline
   typedef struct packed {
      logic vld;
      logic last;
   } ctrl_type;

endpackage

>>> rtl/core/flc_cell.sv
module flc_cell (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic                                   shift,
   input  logic                                   clr,
   input  logic                                   tap_on,
   input  logic                                   coef_we,
   input  logic signed [flc_pkg::SAMPLE_BITS-1:0] coef_data,
   input  logic signed [flc_pkg::SAMPLE_BITS-1:0] nbr_sample,
   output logic signed [flc_pkg::SAMPLE_BITS-1:0] sample,
   output logic signed [flc_pkg::PROD_BITS-1:0]   prod
);
   import flc_pkg::*;

   logic signed [SAMPLE_BITS-1:0] coef_ff;
   logic signed [SAMPLE_BITS-1:0] hist_ff;
   logic signed [SAMPLE_BITS-1:0] hist_in;
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic signed [PROD_BITS-1:0]   prod_in;

   // sample arriving from the neighbour, dropped when the history is cleared
   assign hist_in = clr ? '0 : nbr_sample;

   // product of the arriving sample, zero for a tap beyond the kernel length
   assign prod_in = tap_on ? PROD_BITS'(coef_ff * nbr_sample) : '0;

   // coefficient store
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_ff <= coef_data;
      end
   end

   // history tap, reset to zero
   always_ff @(posedge clock) begin
      if (clr) begin
         hist_ff <= '0;
      end else if (shift) begin
         hist_ff <= hist_in;
      end
   end

   // product register
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign sample = hist_ff;
   assign prod   = prod_ff;

endmodule

>>> rtl/core/flc_adder_tree.sv
module flc_adder_tree (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  flc_pkg::ctrl_type                    leaf_ctrl,
   input  logic signed [flc_pkg::PROD_BITS-1:0] leaf [flc_pkg::MAX_TAPS],
   output logic signed [flc_pkg::ACC_BITS-1:0]  sum,
   output flc_pkg::ctrl_type                    sum_ctrl
);
   import flc_pkg::*;

   localparam int EXT_BITS = ACC_BITS - PROD_BITS;

   logic signed [ACC_BITS-1:0] leaf_ext [LEAVES];
   logic signed [ACC_BITS-1:0] node_ff  [NODES];
   logic signed [ACC_BITS-1:0] node_in  [NODES];
   ctrl_type                   ctrl_ff  [LEVELS];

   // sign extend the products, padding leaves are zero
   for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
      if (g < MAX_TAPS) begin : g_used
         assign leaf_ext[g] = {{EXT_BITS{leaf[g][PROD_BITS-1]}}, leaf[g]};
      end else begin : g_pad
         assign leaf_ext[g] = '0;
      end
   end

   // one adder per node, children at 2n+1 and 2n+2
   for (genvar n = 0; n < NODES; n++) begin : g_node
      if (2 * n + 1 >= NODES) begin : g_bottom
         assign node_in[n] = leaf_ext[2 * n + 1 - NODES] + leaf_ext[2 * n + 2 - NODES];
      end else begin : g_inner
         assign node_in[n] = node_ff[2 * n + 1] + node_ff[2 * n + 2];
      end
   end

   // node registers
   always_ff @(posedge clock) begin
      if (en) begin
         for (int n = 0; n < NODES; n++) begin
            node_ff[n] <= node_in[n];
         end
      end
   end

   // control delay matching the tree depth
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LEVELS; k++) begin
            ctrl_ff[k] <= '0;
         end
      end else if (en) begin
         ctrl_ff[0] <= leaf_ctrl;
         for (int k = 1; k < LEVELS; k++) begin
            ctrl_ff[k] <= ctrl_ff[k-1];
         end
      end
   end

   assign sum      = node_ff[0];
   assign sum_ctrl = ctrl_ff[LEVELS-1];

endmodule

>>> rtl/core/full_linear_convolution_top.sv
// Streaming FIR filter giving the full linear convolution of a signal with
// a loaded kernel.
// Input channel req_*: req_func selects a coefficient load (written at
// req_coef_index) or a signal sample. A sample word with req_end_of_signal
// set is the last of its signal; after it the block pushes tap_count-1 zero
// words of its own to produce the convolution tail, then clears the history.
// Result channel rsp_*: one word per sample and per tail step, with
// rsp_last_output on the final word of a signal.
// csr_wr_en / csr_wr_data write tap_count (0 acts as 1, above 32 as 32).
// The cell products are registered on the edge that takes the word, then
// pass through the registered adder tree. Throughput is one sample per
// cycle while the receiver does not stall; after an end of signal word
// the input is held off while the tail is pushed.
// When the receiver stalls, the whole pipeline holds and req_stall is raised.
// Reset (synchronous) empties the pipeline, zeroes the history and sets
// tap_count to 32; coefficients must be loaded before use.
module full_linear_convolution_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_func,
   input  logic [flc_pkg::IDX_BITS-1:0]           req_coef_index,
   input  logic signed [flc_pkg::SAMPLE_BITS-1:0] req_value,
   input  logic                                   req_end_of_signal,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [flc_pkg::ACC_BITS-1:0]    rsp_filtered_value,
   output logic                                   rsp_last_output,
   input  logic                                   csr_wr_en,
   input  logic [flc_pkg::TAP_BITS-1:0]           csr_wr_data
);
   import flc_pkg::*;

   logic [TAP_BITS-1:0]           tap_count_ff;
   logic [TAP_BITS-1:0]           taps;
   logic                          advance;
   logic                          accept;
   logic                          smp_acc;
   logic                          load;
   logic                          push;
   logic                          last;
   logic                          clr;
   logic signed [SAMPLE_BITS-1:0] push_data;
   logic                          flush_ff;
   logic                          flush_in;
   logic [TAP_BITS-1:0]           flush_cnt_ff;
   logic [TAP_BITS-1:0]           flush_cnt_in;
   ctrl_type                      ctrl0_ff;
   ctrl_type                      out_ctrl;
   logic signed [SAMPLE_BITS-1:0] samples [MAX_TAPS];
   logic signed [PROD_BITS-1:0]   prods   [MAX_TAPS];

   // tap count register
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_BITS'(MAX_TAPS);
      end else if (csr_wr_en) begin
         tap_count_ff <= csr_wr_data;
      end
   end

   // kernel length in use
   always_comb begin
      if (tap_count_ff == '0) begin
         taps = TAP_BITS'(1);
      end else if (tap_count_ff > TAP_BITS'(MAX_TAPS)) begin
         taps = TAP_BITS'(MAX_TAPS);
      end else begin
         taps = tap_count_ff;
      end
   end

   // handshake and push decode
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance || flush_ff;
   assign accept    = req_valid && !req_stall;
   assign smp_acc   = accept && (req_func == FUNC_SAMPLE);
   assign load      = accept && (req_func == FUNC_LOAD);
   assign push      = smp_acc || (flush_ff && advance);
   assign push_data = flush_ff ? '0 : req_value;

   // final word of a signal, after which the history is cleared
   always_comb begin
      if (flush_ff) begin
         last = (flush_cnt_ff == TAP_BITS'(1));
      end else begin
         last = req_end_of_signal && (taps == TAP_BITS'(1));
      end
   end
   assign clr = push && last;

   // tail flush sequencing
   always_comb begin
      flush_in     = flush_ff;
      flush_cnt_in = flush_cnt_ff;
      if (flush_ff && advance) begin
         flush_cnt_in = flush_cnt_ff - TAP_BITS'(1);
         if (flush_cnt_ff == TAP_BITS'(1)) begin
            flush_in = 1'b0;
         end
      end else if (smp_acc && req_end_of_signal && (taps != TAP_BITS'(1))) begin
         flush_in     = 1'b1;
         flush_cnt_in = taps - TAP_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flush_ff     <= 1'b0;
         flush_cnt_ff <= '0;
         ctrl0_ff     <= '0;
      end else begin
         flush_ff     <= flush_in;
         flush_cnt_ff <= flush_cnt_in;
         if (advance) begin
            ctrl0_ff.vld  <= push;
            ctrl0_ff.last <= last;
         end
      end
   end

   // chain of tap cells, the history moving one cell along per push
   for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] nbr;
      if (j == 0) begin : g_head
         assign nbr = push_data;
      end else begin : g_body
         assign nbr = samples[j-1];
      end
      flc_cell u_cell (
         .clock      (clock),
         .en         (advance),
         .shift      (push),
         .clr        (clr || reset),
         .tap_on     (taps > TAP_BITS'(j)),
         .coef_we    (load && (req_coef_index == IDX_BITS'(j))),
         .coef_data  (req_value),
         .nbr_sample (nbr),
         .sample     (samples[j]),
         .prod       (prods[j])
      );
   end

   // registered sum of the tap products
   flc_adder_tree u_tree (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .leaf_ctrl (ctrl0_ff),
      .leaf      (prods),
      .sum       (rsp_filtered_value),
      .sum_ctrl  (out_ctrl)
   );

   assign rsp_valid       = out_ctrl.vld;
   assign rsp_last_output = out_ctrl.last;

`ifndef SYNTHESIS
   // a running flush never has a spent counter
   a_flush_cnt : assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> (flush_cnt_ff != '0))
      else $error("flush active with zero count");

   // an end of signal word on a multi-tap kernel starts the tail
   a_flush_start : assert property (@(posedge clock) disable iff (reset)
      (smp_acc && req_end_of_signal && (taps != TAP_BITS'(1)))
      |=> (flush_ff && (flush_cnt_ff == $past(taps) - TAP_BITS'(1))))
      else $error("tail flush not started");

   // the history is empty after the final word of a signal
   a_hist_clear : assert property (@(posedge clock) disable iff (reset)
      clr |=> ((samples[0] == '0) && (samples[MAX_TAPS-1] == '0)))
      else $error("history not cleared");

   // pushes stop while the result stage is blocked
   a_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !push)
      else $error("push while output blocked");
`endif

endmodule
